// ===== sv/bspt_pkg.sv =====
// shared constants, types and helpers for the b-spline span tessellator
`default_nettype none
package bspt_pkg;

  localparam int MAX_POINTS = 256;
  localparam int SAMPLES    = 25;
  localparam int KNOT_DEPTH = MAX_POINTS + 4;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int KNOT_AW    = $clog2(KNOT_DEPTH);
  localparam int CW         = 32;
  localparam int IDX_W      = 9;
  localparam int CNT_W      = 9;
  localparam int SPAN_FIRST = 3;
  localparam int DEGREE     = 3;
  localparam int BASIS_N    = 7;
  localparam int SAMP_W     = $clog2(SAMPLES);
  localparam int REM_W      = $clog2(SAMPLES);
  localparam int QW         = 33;
  localparam int PROD_W     = 64;
  localparam int TERM_W     = 35;
  localparam int SUM_W      = 36;
  localparam int POINT_RESET = 4;

  // reciprocal of the sample count, exact for any 32 bit span
  localparam int RECIP_SHIFT = 35;
  localparam logic [CW-1:0] RECIP_MUL =
    CW'(((64'd1 << RECIP_SHIFT) + SAMPLES - 1) / SAMPLES);

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_POINT = 2'd0;
  localparam mode_t MODE_KNOT  = 2'd1;
  localparam mode_t MODE_DRAW  = 2'd2;

  typedef struct packed {
    logic                 start;
    logic signed [QW-1:0] num;
    logic signed [QW-1:0] den;
  } ratio_req_t;

  typedef struct packed {
    logic                 done;
    logic signed [QW-1:0] q;
  } ratio_rsp_t;

  function automatic logic signed [QW-1:0] sx33(input logic signed [CW-1:0] v);
    return {v[CW-1], v};
  endfunction

  function automatic logic [CW-1:0] mag33(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] t;
    t = v[QW-1] ? -v : v;
    return t[CW-1:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] apply_sign(input logic [PROD_W-1:0] p,
                                                          input logic neg);
    logic signed [TERM_W-1:0] m;
    m = {1'b0, p[PROD_W-1:30]};
    return neg ? -m : m;
  endfunction

endpackage
`default_nettype wire

// ===== sv/bspt_if.sv =====
// request channel interfaces for input items, samples and configuration
`default_nettype none
interface bspt_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  mode;
  logic [bspt_pkg::IDX_W-1:0]  index;
  logic signed [bspt_pkg::CW-1:0] coord_x;
  logic signed [bspt_pkg::CW-1:0] coord_y;
  logic signed [bspt_pkg::CW-1:0] coord_z;
  logic signed [bspt_pkg::CW-1:0] knot_value;
  modport source (output valid, mode, index, coord_x, coord_y, coord_z, knot_value,
                  input ready);
  modport sink (input valid, mode, index, coord_x, coord_y, coord_z, knot_value,
                output ready);
endinterface

interface bspt_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [bspt_pkg::CW-1:0] point_x;
  logic signed [bspt_pkg::CW-1:0] point_y;
  logic signed [bspt_pkg::CW-1:0] point_z;
  logic                           last_sample;
  modport source (output valid, point_x, point_y, point_z, last_sample, input ready);
  modport sink (input valid, point_x, point_y, point_z, last_sample, output ready);
endinterface

interface bspt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bspt_pkg::CNT_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== sv/cubic_bspline_span_tessellator.sv =====
// top level: load memories, sequence cox-de boor evaluation, emit samples
// a load leaves the input ready; a draw request emits 25 samples, each paced
// by the two serial ratio units: 15 basis terms each take a division of up to
// 31 quotient bits, after t is placed by a reciprocal multiply
// reset is synchronous: sequencer idle, no sample pending, point_count 4
// control point and knot memories are not cleared and read as written
`default_nettype none
module cubic_bspline_span_tessellator (
  input wire logic    clk,
  input wire logic    rst_n,
  bspt_in_if.sink     in_chan,
  bspt_out_if.source  out_chan,
  bspt_cfg_if.sink    cfg_chan
);

  localparam int CW     = bspt_pkg::CW;
  localparam int QW     = bspt_pkg::QW;
  localparam int REM_W  = bspt_pkg::REM_W;
  localparam int KAW    = bspt_pkg::KNOT_AW;
  localparam int PAW    = bspt_pkg::PT_AW;
  localparam int STEP_W = 4;
  localparam int SUM_W  = bspt_pkg::SUM_W;
  localparam int TERM_W = bspt_pkg::TERM_W;

  typedef enum logic [3:0] {
    S_IDLE, S_K0, S_K1, S_KD, S_TDIV, S_L0, S_TRD, S_DIV,
    S_MULA, S_MULB, S_SUM, S_FRD, S_FMUL, S_OUT
  } state_t;

  state_t state_r;
  logic [bspt_pkg::CNT_W-1:0] point_count_r;
  logic [bspt_pkg::IDX_W-1:0] j_r, base;
  logic signed [CW-1:0]  k0_r, t_r, kp_r, ka_r, kb_r, kc_r;
  logic [CW-1:0]         d_r;
  logic [CW-1:0]         acc_r, dq_r, acc_nxt;
  logic [REM_W-1:0]      drem_r, dr_r;
  logic [STEP_W-1:0]     cnt_r;
  logic [bspt_pkg::SAMP_W-1:0] samp_r;
  logic [2:0]            m_r;
  logic [1:0]            n_r;
  logic signed [QW-1:0]  b_r [bspt_pkg::BASIS_N];
  logic signed [QW-1:0]  r1_r, r2_r;
  logic                  dn1_r, dn2_r;
  logic [bspt_pkg::PROD_W-1:0] prod_r;
  logic                  psgn_r;
  logic signed [TERM_W-1:0] p1_r;
  logic signed [SUM_W-1:0]  ax_r, ay_r, az_r;
  logic                  out_valid_r, out_last_r;
  logic signed [CW-1:0]  out_x_r, out_y_r, out_z_r;
  bspt_pkg::ratio_req_t  rq1_r, rq2_r;
  bspt_pkg::ratio_rsp_t  rsp1, rsp2;

  logic                  in_acc, kwe, pwe, kre, pre;
  logic [KAW-1:0]        kraddr;
  logic [PAW-1:0]        praddr;
  logic [CW-1:0]         krdata;
  logic [3*CW-1:0]       prdata;
  logic signed [CW-1:0]  kd;
  logic                  term_live, lvl0, ge25, span_ok;
  logic [REM_W:0]        rs25, rs25_sub;
  logic signed [QW-1:0]  span_d;
  logic [CW-1:0]         mul_a, mul_b;
  logic                  mul_neg;
  logic signed [CW-1:0]  pc;
  logic signed [TERM_W-1:0] tcur;
  logic signed [TERM_W:0]   tsum;
  logic signed [QW-1:0]  bnew;

  function automatic logic signed [CW-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (v < -SUM_W'(33'sh080000000)) begin
      return 32'sh80000000;
    end
    return v[CW-1:0];
  endfunction

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign base    = j_r - bspt_pkg::IDX_W'(bspt_pkg::SPAN_FIRST);
  assign kd      = signed'(krdata);
  assign term_live = ({1'b0, m_r} + {2'b00, n_r}) < 4'(bspt_pkg::BASIS_N);
  assign lvl0    = (kp_r <= t_r) && (t_r < kd);
  assign rs25    = {1'b0, drem_r} + {1'b0, dr_r};
  assign ge25    = rs25 >= (REM_W+1)'(bspt_pkg::SAMPLES);
  assign rs25_sub = rs25 - (REM_W+1)'(bspt_pkg::SAMPLES);
  assign acc_nxt = acc_r + dq_r + CW'(ge25);
  assign span_d  = bspt_pkg::sx33(kd) - bspt_pkg::sx33(k0_r);
  assign span_ok = (j_r >= bspt_pkg::IDX_W'(bspt_pkg::SPAN_FIRST)) &&
                   (j_r < point_count_r) &&
                   (j_r < bspt_pkg::IDX_W'(bspt_pkg::MAX_POINTS));
  assign tcur    = bspt_pkg::apply_sign(prod_r, psgn_r);
  assign tsum    = {p1_r[TERM_W-1], p1_r} + {tcur[TERM_W-1], tcur};

  always_comb begin
    if (tsum > (TERM_W+1)'(33'sh080000000)) begin
      bnew = QW'(33'sh080000000);
    end else if (tsum < -(TERM_W+1)'(33'sh080000000)) begin
      bnew = -QW'(33'sh080000000);
    end else begin
      bnew = tsum[QW-1:0];
    end
  end

  assign kwe = in_acc && (in_chan.mode == bspt_pkg::MODE_KNOT) &&
               (in_chan.index < bspt_pkg::IDX_W'(bspt_pkg::KNOT_DEPTH));
  assign pwe = in_acc && (in_chan.mode == bspt_pkg::MODE_POINT) &&
               (in_chan.index < bspt_pkg::IDX_W'(bspt_pkg::MAX_POINTS));

  always_comb begin
    kre    = 1'b0;
    kraddr = j_r;
    unique case (state_r)
      S_K0: begin
        kre = 1'b1;
      end
      S_K1: begin
        kre    = 1'b1;
        kraddr = j_r + 9'd1;
      end
      S_L0: begin
        kre    = cnt_r < STEP_W'(8);
        kraddr = base + KAW'(cnt_r);
      end
      S_TRD: begin
        kre = term_live && (cnt_r < STEP_W'(4));
        case (cnt_r[1:0])
          2'd0:    kraddr = base + KAW'(m_r);
          2'd1:    kraddr = base + KAW'(m_r) + KAW'(n_r);
          2'd2:    kraddr = base + KAW'(m_r) + 9'd1;
          default: kraddr = base + KAW'(m_r) + KAW'(n_r) + 9'd1;
        endcase
      end
      default: begin
        kre = 1'b0;
      end
    endcase
  end

  assign pre    = state_r == S_FRD;
  assign praddr = base[PAW-1:0] + PAW'(m_r);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pc = signed'(prdata[CW-1:0]);
      2'd1:    pc = signed'(prdata[2*CW-1:CW]);
      default: pc = signed'(prdata[3*CW-1:2*CW]);
    endcase
    mul_a   = bspt_pkg::mag33(b_r[0]);
    mul_b   = bspt_pkg::mag33(r1_r);
    mul_neg = b_r[0][QW-1] ^ r1_r[QW-1];
    if (state_r == S_MULB) begin
      mul_a   = bspt_pkg::mag33(b_r[1]);
      mul_b   = bspt_pkg::mag33(r2_r);
      mul_neg = b_r[1][QW-1] ^ r2_r[QW-1];
    end else if (state_r == S_FMUL) begin
      mul_b   = bspt_pkg::mag33(bspt_pkg::sx33(pc));
      mul_neg = b_r[0][QW-1] ^ pc[CW-1];
    end
  end

  bspt_ram #(.WIDTH(CW), .DEPTH(bspt_pkg::KNOT_DEPTH)) u_knot_ram (
    .clk(clk), .we(kwe), .waddr(in_chan.index[KAW-1:0]), .wdata(in_chan.knot_value),
    .re(kre), .raddr(kraddr), .rdata(krdata)
  );

  bspt_ram #(.WIDTH(3*CW), .DEPTH(bspt_pkg::MAX_POINTS)) u_point_ram (
    .clk(clk), .we(pwe), .waddr(in_chan.index[PAW-1:0]),
    .wdata({in_chan.coord_z, in_chan.coord_y, in_chan.coord_x}),
    .re(pre), .raddr(praddr), .rdata(prdata)
  );

  bspt_ratio u_ratio1 (.clk(clk), .rst_n(rst_n), .req(rq1_r), .rsp(rsp1));
  bspt_ratio u_ratio2 (.clk(clk), .rst_n(rst_n), .req(rq2_r), .rsp(rsp2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      point_count_r <= bspt_pkg::CNT_W'(bspt_pkg::POINT_RESET);
      rq1_r.start   <= 1'b0;
      rq2_r.start   <= 1'b0;
      dn1_r         <= 1'b0;
      dn2_r         <= 1'b0;
    end else begin
      rq1_r.start <= 1'b0;
      rq2_r.start <= 1'b0;
      if (cfg_chan.valid) begin
        point_count_r <= cfg_chan.data;
      end
      if (out_valid_r && out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc && (in_chan.mode == bspt_pkg::MODE_DRAW)) begin
            j_r     <= in_chan.index;
            state_r <= S_K0;
          end
        end
        S_K0: begin
          state_r <= span_ok ? S_K1 : S_IDLE;
        end
        S_K1: begin
          k0_r    <= kd;
          state_r <= S_KD;
        end
        S_KD: begin
          if (span_d[QW-1] || (span_d == '0)) begin
            state_r <= S_IDLE;
          end else begin
            d_r     <= span_d[CW-1:0];
            acc_r   <= '0;
            drem_r  <= '0;
            cnt_r   <= '0;
            samp_r  <= '0;
            state_r <= S_TDIV;
          end
        end
        S_TDIV: begin
          cnt_r <= cnt_r + STEP_W'(1);
          case (cnt_r[1:0])
            2'd0: begin
              prod_r <= d_r * bspt_pkg::RECIP_MUL;
            end
            2'd1: begin
              dq_r <= CW'(prod_r[bspt_pkg::PROD_W-1:bspt_pkg::RECIP_SHIFT]);
            end
            default: begin
              dr_r    <= d_r[REM_W-1:0] - REM_W'(dq_r * CW'(bspt_pkg::SAMPLES));
              t_r     <= k0_r + signed'(acc_r);
              cnt_r   <= '0;
              state_r <= S_L0;
            end
          endcase
        end
        S_L0: begin
          cnt_r <= cnt_r + STEP_W'(1);
          if (cnt_r != '0) begin
            kp_r <= kd;
          end
          if (cnt_r >= STEP_W'(2)) begin
            for (int i = 0; i < bspt_pkg::BASIS_N - 1; i++) begin
              b_r[i] <= b_r[i+1];
            end
            b_r[bspt_pkg::BASIS_N-1] <= lvl0 ? QW'(33'sh040000000) : '0;
          end
          if (cnt_r == STEP_W'(8)) begin
            n_r     <= 2'd1;
            m_r     <= '0;
            cnt_r   <= '0;
            state_r <= S_TRD;
          end
        end
        S_TRD: begin
          if (!term_live) begin
            for (int i = 0; i < bspt_pkg::BASIS_N - 1; i++) begin
              b_r[i] <= b_r[i+1];
            end
            b_r[bspt_pkg::BASIS_N-1] <= b_r[0];
            cnt_r <= '0;
            if (m_r == 3'd6) begin
              m_r <= '0;
              if (n_r == 2'(bspt_pkg::DEGREE)) begin
                ax_r    <= '0;
                ay_r    <= '0;
                az_r    <= '0;
                state_r <= S_FRD;
              end else begin
                n_r <= n_r + 2'd1;
              end
            end else begin
              m_r <= m_r + 3'd1;
            end
          end else begin
            cnt_r <= cnt_r + STEP_W'(1);
            case (cnt_r[2:0])
              3'd1:    ka_r <= kd;
              3'd2:    kb_r <= kd;
              3'd3:    kc_r <= kd;
              3'd4: begin
                rq1_r   <= '{start: 1'b1,
                             num: bspt_pkg::sx33(t_r) - bspt_pkg::sx33(ka_r),
                             den: bspt_pkg::sx33(kb_r) - bspt_pkg::sx33(ka_r)};
                rq2_r   <= '{start: 1'b1,
                             num: bspt_pkg::sx33(kd) - bspt_pkg::sx33(t_r),
                             den: bspt_pkg::sx33(kd) - bspt_pkg::sx33(kc_r)};
                state_r <= S_DIV;
              end
              default: begin
              end
            endcase
          end
        end
        S_DIV: begin
          if (rsp1.done) begin
            r1_r  <= rsp1.q;
            dn1_r <= 1'b1;
          end
          if (rsp2.done) begin
            r2_r  <= rsp2.q;
            dn2_r <= 1'b1;
          end
          if ((dn1_r || rsp1.done) && (dn2_r || rsp2.done)) begin
            dn1_r   <= 1'b0;
            dn2_r   <= 1'b0;
            state_r <= S_MULA;
          end
        end
        S_MULA: begin
          prod_r  <= mul_a * mul_b;
          psgn_r  <= mul_neg;
          state_r <= S_MULB;
        end
        S_MULB: begin
          p1_r    <= tcur;
          prod_r  <= mul_a * mul_b;
          psgn_r  <= mul_neg;
          state_r <= S_SUM;
        end
        S_SUM: begin
          for (int i = 0; i < bspt_pkg::BASIS_N - 1; i++) begin
            b_r[i] <= b_r[i+1];
          end
          b_r[bspt_pkg::BASIS_N-1] <= bnew;
          cnt_r   <= '0;
          state_r <= S_TRD;
          if (m_r == 3'd6) begin
            m_r <= '0;
            if (n_r == 2'(bspt_pkg::DEGREE)) begin
              ax_r    <= '0;
              ay_r    <= '0;
              az_r    <= '0;
              state_r <= S_FRD;
            end else begin
              n_r <= n_r + 2'd1;
            end
          end else begin
            m_r <= m_r + 3'd1;
          end
        end
        S_FRD: begin
          cnt_r   <= '0;
          state_r <= S_FMUL;
        end
        S_FMUL: begin
          cnt_r <= cnt_r + STEP_W'(1);
          if (cnt_r < STEP_W'(3)) begin
            prod_r <= mul_a * mul_b;
            psgn_r <= mul_neg;
          end
          case (cnt_r[1:0])
            2'd1:    ax_r <= ax_r + SUM_W'(tcur);
            2'd2:    ay_r <= ay_r + SUM_W'(tcur);
            2'd3:    az_r <= az_r + SUM_W'(tcur);
            default: begin
            end
          endcase
          if (cnt_r == STEP_W'(3)) begin
            for (int i = 0; i < bspt_pkg::BASIS_N - 1; i++) begin
              b_r[i] <= b_r[i+1];
            end
            b_r[bspt_pkg::BASIS_N-1] <= b_r[0];
            if (m_r == 3'd3) begin
              state_r <= S_OUT;
            end else begin
              m_r     <= m_r + 3'd1;
              state_r <= S_FRD;
            end
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_x_r     <= sat32(ax_r);
            out_y_r     <= sat32(ay_r);
            out_z_r     <= sat32(az_r);
            out_last_r  <= samp_r == bspt_pkg::SAMP_W'(bspt_pkg::SAMPLES - 1);
            if (samp_r == bspt_pkg::SAMP_W'(bspt_pkg::SAMPLES - 1)) begin
              state_r <= S_IDLE;
            end else begin
              samp_r  <= samp_r + bspt_pkg::SAMP_W'(1);
              acc_r   <= acc_nxt;
              drem_r  <= ge25 ? rs25_sub[REM_W-1:0] : rs25[REM_W-1:0];
              cnt_r   <= '0;
              state_r <= S_TDIV;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_chan.ready        = state_r == S_IDLE;
  assign cfg_chan.ready       = 1'b1;
  assign out_chan.valid       = out_valid_r;
  assign out_chan.point_x     = out_x_r;
  assign out_chan.point_y     = out_y_r;
  assign out_chan.point_z     = out_z_r;
  assign out_chan.last_sample = out_last_r;

endmodule
`default_nettype wire

// ===== sv/bspt_ram.sv =====
// generic single write, single read ram with registered read data
`default_nettype none
module bspt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bspt_ratio.sv =====
// serial q2.30 ratio unit, one quotient bit per cycle, saturated to +-2.0, zero result for a zero divisor
`default_nettype none
module bspt_ratio (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire bspt_pkg::ratio_req_t req,
  output bspt_pkg::ratio_rsp_t      rsp
);

  localparam int QW = bspt_pkg::QW;

  logic              busy_r, done_r, neg_r, lsb_r;
  logic [4:0]        cnt_r;
  logic [QW-1:0]     rem_r, ud_r;
  logic [30:0]       q_r;
  logic signed [QW-1:0] res_r;

  logic [QW-1:0]     un, ud;
  logic              neg, big;
  logic [QW:0]       rs, diff;
  logic              ge;
  logic [30:0]       q_nxt;

  always_comb begin
    neg   = req.num[QW-1] ^ req.den[QW-1];
    un    = req.num[QW-1] ? QW'(-req.num) : QW'(req.num);
    ud    = req.den[QW-1] ? QW'(-req.den) : QW'(req.den);
    big   = {1'b0, un} >= {ud, 1'b0};
    rs    = {rem_r, (cnt_r == 5'd0) ? lsb_r : 1'b0};
    ge    = rs >= {1'b0, ud_r};
    diff  = rs - {1'b0, ud_r};
    q_nxt = {q_r[29:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        neg_r <= neg;
        if (req.den == '0) begin
          res_r  <= '0;
          done_r <= 1'b1;
        end else if (big) begin
          res_r  <= neg ? -(QW'(1) <<< 31) : (QW'(1) <<< 31);
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          rem_r  <= {1'b0, un[QW-1:1]};
          ud_r   <= ud;
          lsb_r  <= un[0];
          cnt_r  <= '0;
          q_r    <= '0;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[QW-1:0] : rs[QW-1:0];
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd30) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -{2'b00, q_nxt} : {2'b00, q_nxt};
        end
      end
    end
  end

  assign rsp = '{done: done_r, q: res_r};

endmodule
`default_nettype wire

// ===== sv/bspt_checker.sv =====
// port level checks for the tessellator and their binding
`default_nettype none
module bspt_checker (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [1:0]           in_mode,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [bspt_pkg::CW-1:0] out_x,
  input wire logic                 out_last
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == bspt_pkg::MODE_DRAW) |=> !in_ready)
    else $error("draw request did not occupy the sequencer");

  a_load_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready &&
    (in_mode == bspt_pkg::MODE_POINT || in_mode == bspt_pkg::MODE_KNOT) |=> in_ready)
    else $error("load request stalled the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_last))
    else $error("stalled sample changed");

endmodule

bind cubic_bspline_span_tessellator bspt_checker u_bspt_checker (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_chan.valid), .in_ready(in_chan.ready), .in_mode(in_chan.mode),
  .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .out_x(out_chan.point_x), .out_last(out_chan.last_sample)
);
`default_nettype wire

// ===== test/cubic_bspline_span_tessellator_tb.sv =====
// self-checking testbench for the cubic b-spline span tessellator
module cubic_bspline_span_tessellator_tb;
  import bspt_pkg::*;

  localparam longint ONE_Q30 = 64'sd1 <<< 30;
  localparam longint LIM_Q30 = 64'sd1 <<< 31;
  localparam int IDLE_LIMIT = 60000;
  localparam int SETTLE_CYCLES = 18000;
  localparam int ITEM_TARGET = 110;
  localparam mode_t MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 last;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bspt_in_if  in_if();
  bspt_out_if out_if();
  bspt_cfg_if cfg_if();

  cubic_bspline_span_tessellator dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if.sink),
    .out_chan (out_if.source),
    .cfg_chan (cfg_if.sink)
  );

  always #1 clk = ~clk;

  sample_t pending_samples[$];
  longint  knot_mirror[KNOT_DEPTH];
  longint  point_mirror[MAX_POINTS][3];
  int      count_mirror;
  int      errors;
  int      items_sent;
  int      idle_cycles;
  int      holdoff_cycles;
  int      stall_left;
  bit      quiet;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint clamp_q30(longint v);
    if (v > LIM_Q30) return LIM_Q30;
    if (v < -LIM_Q30) return -LIM_Q30;
    return v;
  endfunction

  function automatic longint ratio_q30(longint num, longint den);
    longint unsigned un, ud, q;
    bit neg;
    if (den == 0) return 0;
    neg = (num < 0) != (den < 0);
    un = mag64(num);
    ud = mag64(den);
    if (un >= 2 * ud) q = LIM_Q30;
    else q = (un << 30) / ud;
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint mul_q30(longint a, longint b);
    longint unsigned p;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = (mag64(a) * mag64(b)) >> 30;
    return neg ? -longint'(p) : longint'(p);
  endfunction

  function automatic sample_t curve_point(int j, longint t, bit last);
    longint basis[7];
    longint acc[3];
    longint r1, r2;
    int base;
    sample_t s;
    base = j - 3;
    for (int m = 0; m < 7; m++)
      basis[m] = (knot_mirror[base+m] <= t && t < knot_mirror[base+m+1]) ? ONE_Q30 : 0;
    for (int n = 1; n <= 3; n++) begin
      for (int m = 0; m + n < 7; m++) begin
        r1 = ratio_q30(t - knot_mirror[base+m], knot_mirror[base+m+n] - knot_mirror[base+m]);
        r2 = ratio_q30(knot_mirror[base+m+n+1] - t,
                       knot_mirror[base+m+n+1] - knot_mirror[base+m+1]);
        basis[m] = clamp_q30(mul_q30(r1, basis[m]) + mul_q30(r2, basis[m+1]));
      end
    end
    for (int c = 0; c < 3; c++) begin
      acc[c] = 0;
      for (int i = 0; i < 4; i++) acc[c] += mul_q30(point_mirror[base+i][c], basis[i]);
      if (acc[c] > 64'sd2147483647) acc[c] = 64'sd2147483647;
      if (acc[c] < -64'sd2147483648) acc[c] = -64'sd2147483648;
    end
    s.x = acc[0][31:0];
    s.y = acc[1][31:0];
    s.z = acc[2][31:0];
    s.last = last;
    return s;
  endfunction

  // mirror of the block for one accepted request
  task automatic apply_request(mode_t mode, int idx, logic signed [CW-1:0] x,
                               logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                               logic signed [CW-1:0] k);
    int eff;
    longint k0, d, t;
    case (mode)
      MODE_POINT: begin
        if (idx < MAX_POINTS) begin
          point_mirror[idx][0] = x;
          point_mirror[idx][1] = y;
          point_mirror[idx][2] = z;
        end
      end
      MODE_KNOT: begin
        if (idx < KNOT_DEPTH) knot_mirror[idx] = k;
      end
      MODE_DRAW: begin
        eff = count_mirror < MAX_POINTS ? count_mirror : MAX_POINTS;
        if (idx >= SPAN_FIRST && idx < eff) begin
          k0 = knot_mirror[idx];
          d = knot_mirror[idx+1] - k0;
          if (d > 0) begin
            for (int s = 0; s < SAMPLES; s++) begin
              t = k0 + longint'((longint'(d) * s) / SAMPLES);
              pending_samples.push_back(curve_point(idx, t, s == SAMPLES - 1));
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  task automatic send_request(mode_t mode, int idx, logic signed [CW-1:0] x,
                              logic signed [CW-1:0] y, logic signed [CW-1:0] z,
                              logic signed [CW-1:0] k);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.mode = mode;
    in_if.index = idx[IDX_W-1:0];
    in_if.coord_x = x;
    in_if.coord_y = y;
    in_if.coord_z = z;
    in_if.knot_value = k;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    apply_request(mode, idx, x, y, z, k);
    items_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic load_point(int idx, logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z);
    send_request(MODE_POINT, idx, x, y, z, $urandom());
  endtask

  task automatic load_knot(int idx, logic signed [CW-1:0] k);
    send_request(MODE_KNOT, idx, $urandom(), $urandom(), $urandom(), k);
  endtask

  task automatic draw_span(int j);
    send_request(MODE_DRAW, j, $urandom(), $urandom(), $urandom(), $urandom());
  endtask

  task automatic write_count(int value);
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.data = value[CNT_W-1:0];
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    count_mirror = value;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  function automatic logic signed [CW-1:0] random_coord();
    case ($urandom_range(0, 3))
      0: return $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
      1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // knot vector 0..10 covering spans 3..6; shape 0 rising, 1 repeated, 2 disordered
  task automatic load_knot_vector(int shape);
    longint steps[10];
    longint total, start, v, scale;
    total = 0;
    case ($urandom_range(0, 2))
      0: scale = 16;
      1: scale = 64'd1 << 18;
      default: scale = 64'd1 << 28;
    endcase
    for (int i = 0; i < 10; i++) begin
      steps[i] = $urandom_range(1, int'(scale));
      if (shape == 1 && $urandom_range(0, 2) == 0) steps[i] = 0;
      if (shape == 2 && $urandom_range(0, 2) == 0) steps[i] = -steps[i];
      if (steps[i] > 0) total += steps[i];
    end
    start = -64'sd2147483648 + longint'($urandom_range(0, 32'hffff_ffff - int'(total)));
    if (shape == 2) start = start / 4;
    v = start;
    for (int i = 0; i <= 10; i++) begin
      load_knot(i, v[31:0]);
      if (i < 10) v += steps[i];
    end
  endtask

  task automatic test_reset_count_and_corners();
    write_count(4);
    load_point(0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    load_point(1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    load_point(2, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh0001_0000);
    for (int i = 3; i < 7; i++) load_point(i, random_coord(), random_coord(), random_coord());
    load_knot(0, 32'sh8000_0000);
    load_knot(1, -32'sh4000_0000);
    load_knot(2, -32'sh0001_0000);
    load_knot(3, 32'sh0000_0000);
    load_knot(4, 32'sh0003_0000);
    load_knot(5, 32'sh0003_0000);
    load_knot(6, 32'sh0010_0000);
    load_knot(7, 32'sh0100_0000);
    load_knot(8, 32'sh1000_0000);
    load_knot(9, 32'sh4000_0000);
    load_knot(10, 32'sh7fff_ffff);
    // out of range loads and the unused mode are dropped
    send_request(MODE_POINT, MAX_POINTS, '1, '1, '1, '1);
    send_request(MODE_KNOT, KNOT_DEPTH, '1, '1, '1, '1);
    send_request(MODE_KNOT, 511, '1, '1, '1, '1);
    send_request(MODE_UNUSED, 3, '1, '1, '1, '1);
    draw_span(3);
    draw_span(2);
    draw_span(4);
  endtask

  task automatic test_span_limits();
    write_count(7);
    draw_span(4);
    draw_span(6);
    draw_span(7);
    draw_span(5);
  endtask

  task automatic test_output_backpressure();
    quiet = 1'b1;
    holdoff_cycles = 3000;
    draw_span(3);
    draw_span(6);
    draw_span(5);
    draw_span(6);
    quiet = 1'b0;
  endtask

  task automatic random_span_sequence();
    int r, eff;
    r = $urandom_range(0, 9);
    load_knot_vector(r < 6 ? 0 : (r < 9 ? 1 : 2));
    repeat ($urandom_range(1, 3))
      load_point($urandom_range(0, 6), random_coord(), random_coord(), random_coord());
    repeat ($urandom_range(2, 3)) draw_span($urandom_range(3, 6));
    if ($urandom_range(0, 2) == 0) begin
      eff = count_mirror < MAX_POINTS ? count_mirror : MAX_POINTS;
      case ($urandom_range(0, 3))
        0: draw_span($urandom_range(0, 2));
        1: draw_span($urandom_range(eff > 7 ? eff : 7, 511));
        2: send_request(MODE_UNUSED, $urandom_range(0, 511), $urandom(), $urandom(),
                        $urandom(), $urandom());
        default: send_request($urandom_range(0, 1) ? MODE_POINT : MODE_KNOT,
                              $urandom_range(KNOT_DEPTH, 511), $urandom(), $urandom(),
                              $urandom(), $urandom());
      endcase
    end
  endtask

  task automatic test_random_spans();
    while (items_sent < 60) random_span_sequence();
    write_count(MAX_POINTS);
    while (items_sent < 78) random_span_sequence();
    write_count(511);
    while (items_sent < 94) random_span_sequence();
    write_count($urandom_range(4, 10));
    while (items_sent < ITEM_TARGET) random_span_sequence();
  endtask

  always @(negedge clk) begin
    if (holdoff_cycles > 0) begin
      out_if.ready = 1'b0;
      holdoff_cycles--;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else begin
      out_if.ready = 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    sample_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_samples.size() == 0) begin
        report("sample with none expected");
      end else begin
        want = pending_samples.pop_front();
        if (out_if.point_x !== want.x)
          report($sformatf("point_x %h, expected %h", out_if.point_x, want.x));
        if (out_if.point_y !== want.y)
          report($sformatf("point_y %h, expected %h", out_if.point_y, want.y));
        if (out_if.point_z !== want.z)
          report($sformatf("point_z %h, expected %h", out_if.point_z, want.z));
        if (out_if.last_sample !== want.last)
          report($sformatf("last_sample %b, expected %b", out_if.last_sample, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("cubic_bspline_span_tessellator regression: fail");
        $finish;
      end
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = MODE_POINT;
    in_if.index = '0;
    in_if.coord_x = '0;
    in_if.coord_y = '0;
    in_if.coord_z = '0;
    in_if.knot_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    count_mirror = POINT_RESET;
    errors = 0;
    items_sent = 0;
    idle_cycles = 0;
    holdoff_cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    for (int i = 0; i < KNOT_DEPTH; i++) knot_mirror[i] = 0;
    for (int i = 0; i < MAX_POINTS; i++) point_mirror[i] = '{0, 0, 0};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    test_reset_count_and_corners();
    test_span_limits();
    test_output_backpressure();
    test_random_spans();
    while (pending_samples.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (errors == 0) $display("cubic_bspline_span_tessellator regression: pass");
    else $display("cubic_bspline_span_tessellator regression: fail");
    $finish;
  end

endmodule
